// ----- design/tss_pkg.sv -----
// ----------------------------------------------------------------------------
// tss_pkg
// Shared types and codes of the transaction slot server.
// ----------------------------------------------------------------------------
package tss_pkg;

  typedef enum logic [2:0] {
    OP_CALL, OP_RECALL, OP_ACK, OP_SENDRET, OP_TICK, OP_LREPLY, OP_LCANCEL, OP_ABORT
  } op_t;

  localparam logic [2:0] ACT_NONE    = 3'd0;
  localparam logic [2:0] ACT_DELIVER = 3'd1;
  localparam logic [2:0] ACT_RET     = 3'd2;
  localparam logic [2:0] ACT_CANCEL  = 3'd3;
  localparam logic [2:0] ACT_NOINFO  = 3'd4;
  localparam logic [2:0] ACT_RERET   = 3'd5;

  localparam logic [3:0] EV_OK        = 4'd0;
  localparam logic [3:0] EV_DUP       = 4'd1;
  localparam logic [3:0] EV_NOFREE    = 4'd2;
  localparam logic [3:0] EV_NOSLOT    = 4'd3;
  localparam logic [3:0] EV_DONE      = 4'd4;
  localparam logic [3:0] EV_CLCANCEL  = 4'd5;
  localparam logic [3:0] EV_CANCELLED = 4'd6;
  localparam logic [3:0] EV_TIMEOUT   = 4'd7;
  localparam logic [3:0] EV_ABORTED   = 4'd8;

  localparam logic [1:0] PH_PENDING   = 2'd0;
  localparam logic [1:0] PH_READY     = 2'd1;
  localparam logic [1:0] PH_CANCELLED = 2'd2;

  localparam logic [1:0] REG_RETRY_INTERVAL = 2'd0;
  localparam logic [1:0] REG_MAX_RETRIES    = 2'd1;
  localparam logic [1:0] REG_HANDLER        = 2'd2;

  localparam logic [15:0] RETRY_INTERVAL_RST = 16'd10;
  localparam logic [7:0]  MAX_RETRIES_RST    = 8'd3;

  typedef struct packed {
    logic [15:0] retry_interval;
    logic [7:0]  max_retries;
    logic        handler_attached;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  phase;
    logic [15:0] endpoint;
    logic [31:0] trans_key;
    logic [31:0] client;
    logic [31:0] serial;
    logic [15:0] countdown;
    logic [7:0]  retries;
  } slot_rec_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [3:0]  event_res;
    logic [15:0] endpoint;
    logic [31:0] trans_key;
    logic [31:0] client_no;
    logic [31:0] server_no;
    logic [31:0] serial;
    logic        last;
  } res_t;

endpackage

// ----- design/transaction_slot_server.sv -----
// ----------------------------------------------------------------------------
// transaction_slot_server
// Server side of a request/response transaction protocol with a slot table.
// ----------------------------------------------------------------------------
// Ack, sendret and local reply/cancel read the addressed slot when it is busy; a
// call or recall searches the active slots one by one for its key first.
// A tick walks the active slots, and an abort reports and frees them one by one.
// One item is worked at a time, through the single read port of the slot RAM.
// Results are single-cycle strobes; the receiver cannot stall them.
// Synchronous reset empties the active list and refills the free list at once.
module transaction_slot_server #(
  parameter int SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_op,
  input  logic [15:0] in_endpoint,
  input  logic [31:0] in_trans_key,
  input  logic [31:0] in_client_id,
  input  logic [31:0] in_server_id,
  input  logic [31:0] in_recall_count,
  input  logic [31:0] in_local_serial,
  output logic        out_valid,
  output logic [2:0]  out_action,
  output logic [3:0]  out_event_res,
  output logic [15:0] out_reply_endpoint,
  output logic [31:0] out_reply_trans_key,
  output logic [31:0] out_reply_client,
  output logic [31:0] out_reply_server,
  output logic [31:0] out_reply_serial,
  output logic        out_last
);
  import tss_pkg::*;

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  cfg_t          cfg;
  res_t          res;
  logic [IW-1:0] raddr;
  logic [IW-1:0] waddr;
  logic          we;
  slot_rec_t     rdata;
  slot_rec_t     wdata;
  logic          recall_seen;

  assign recall_seen = ^in_recall_count;

  tss_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tss_ram #(
    .WIDTH ($bits(slot_rec_t)),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  tss_ctrl #(
    .SLOTS (SLOTS)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg),
    .start           (start && (recall_seen || !recall_seen)),
    .in_op           (in_op),
    .in_endpoint     (in_endpoint),
    .in_trans_key    (in_trans_key),
    .in_client_id    (in_client_id),
    .in_server_id    (in_server_id),
    .in_local_serial (in_local_serial),
    .busy            (busy),
    .res             (res),
    .res_valid       (out_valid),
    .ram_raddr       (raddr),
    .ram_rdata       (rdata),
    .ram_we          (we),
    .ram_waddr       (waddr),
    .ram_wdata       (wdata)
  );

  assign out_action          = res.action;
  assign out_event_res       = res.event_res;
  assign out_reply_endpoint  = res.endpoint;
  assign out_reply_trans_key = res.trans_key;
  assign out_reply_client    = res.client_no;
  assign out_reply_server    = res.server_no;
  assign out_reply_serial    = res.serial;
  assign out_last            = res.last;

endmodule

// ----- design/tss_ram.sv -----
// ----------------------------------------------------------------------------
// tss_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/tss_cfg.sv -----
// ----------------------------------------------------------------------------
// tss_cfg
// Configuration registers behind the APB-style port.
// ----------------------------------------------------------------------------
module tss_cfg (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output tss_pkg::cfg_t cfg
);
  import tss_pkg::*;

  cfg_t cfg_r;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.retry_interval   <= RETRY_INTERVAL_RST;
      cfg_r.max_retries      <= MAX_RETRIES_RST;
      cfg_r.handler_attached <= 1'b0;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_RETRY_INTERVAL: cfg_r.retry_interval <= pwdata[15:0];
        REG_MAX_RETRIES:    cfg_r.max_retries <= pwdata[7:0];
        REG_HANDLER:        cfg_r.handler_attached <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_RETRY_INTERVAL: prdata = {16'd0, cfg_r.retry_interval};
      REG_MAX_RETRIES:    prdata = {24'd0, cfg_r.max_retries};
      REG_HANDLER:        prdata = {31'd0, cfg_r.handler_attached};
      default:            prdata = 32'd0;
    endcase
  end

endmodule

// ----- design/tss_ctrl.sv -----
// ----------------------------------------------------------------------------
// tss_ctrl
// Sequencer of the slot server: key search, slot start, direct slot access,
// tick walk and abort, all by reads and, where a slot changes, writes of the slot RAM.
// ----------------------------------------------------------------------------
module tss_ctrl #(
  parameter int SLOTS = 16,
  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1,
  localparam int CW = $clog2(SLOTS + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  tss_pkg::cfg_t      cfg,
  input  logic               start,
  input  logic [2:0]         in_op,
  input  logic [15:0]        in_endpoint,
  input  logic [31:0]        in_trans_key,
  input  logic [31:0]        in_client_id,
  input  logic [31:0]        in_server_id,
  input  logic [31:0]        in_local_serial,
  output logic               busy,
  output tss_pkg::res_t      res,
  output logic               res_valid,
  output logic [IW-1:0]      ram_raddr,
  input  tss_pkg::slot_rec_t ram_rdata,
  output logic               ram_we,
  output logic [IW-1:0]      ram_waddr,
  output tss_pkg::slot_rec_t ram_wdata
);
  import tss_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_SRD, S_SCMP, S_ST1, S_ST2, S_DRD, S_DEV, S_TRD, S_TEV, S_ARD, S_AEV
  } state_t;

  state_t           state_r;
  op_t              op_r;
  logic [15:0]      ep_r;
  logic [31:0]      key_r;
  logic [31:0]      cl_r;
  logic [31:0]      sv_r;
  logic [31:0]      ser_r;
  logic [IW-1:0]    cur_r;
  logic [CW-1:0]    idx_r;
  logic [CW-1:0]    cnt_r;
  logic [IW-1:0]    free_head_r;
  logic [CW-1:0]    free_cnt_r;
  logic [IW-1:0]    act_r [SLOTS];
  logic [IW-1:0]    free_r [SLOTS];
  logic [SLOTS-1:0] busy_r;
  logic [SLOTS-1:0] armed_r;
  logic [SLOTS-1:0] written_r;
  res_t             res_r;
  logic             res_v_r;
  res_t             pend_r;
  logic             pend_v_r;
  logic             we_r;
  logic [IW-1:0]    waddr_r;
  slot_rec_t        wdata_r;

  logic [IW-1:0]    act_rm [SLOTS];
  logic [IW-1:0]    tail;
  logic [CW:0]      tsum;
  logic             key_match;
  logic             do_rel;
  logic [IW-1:0]    in_slot;
  logic             in_range;
  slot_rec_t        rec;

  function automatic res_t slot_res(logic [2:0] act, logic [3:0] ev, slot_rec_t r,
                                    logic [IW-1:0] s, logic [31:0] serial, logic lst);
    res_t o;
    o.action    = act;
    o.event_res = ev;
    o.endpoint  = r.endpoint;
    o.trans_key = r.trans_key;
    o.client_no = r.client;
    o.server_no = 32'(s);
    o.serial    = serial;
    o.last      = lst;
    return o;
  endfunction

  function automatic res_t echo_res(logic [2:0] act, logic [3:0] ev, logic [15:0] ep,
                                    logic [31:0] key, logic [31:0] cl, logic [31:0] sv);
    res_t o;
    o.action    = act;
    o.event_res = ev;
    o.endpoint  = ep;
    o.trans_key = key;
    o.client_no = cl;
    o.server_no = sv;
    o.serial    = 32'd0;
    o.last      = 1'b1;
    return o;
  endfunction

  assign rec       = ram_rdata;
  assign busy      = (state_r != S_IDLE);
  assign res       = res_r;
  assign res_valid = res_v_r;
  assign ram_we    = we_r;
  assign ram_waddr = waddr_r;
  assign ram_wdata = wdata_r;
  assign key_match = (rec.endpoint == ep_r) && (rec.trans_key == key_r);
  assign in_slot   = in_server_id[IW-1:0];
  assign in_range  = (in_server_id < 32'(SLOTS));

  always_comb begin
    unique case (state_r)
      S_SRD, S_TRD: ram_raddr = act_r[idx_r[IW-1:0]];
      S_ARD:        ram_raddr = act_r[0];
      S_ST1:        ram_raddr = free_r[free_head_r];
      S_DRD:        ram_raddr = sv_r[IW-1:0];
      default:      ram_raddr = cur_r;
    endcase
  end

  always_comb begin
    logic seen;
    seen = 1'b0;
    for (int j = 0; j < SLOTS; j++) begin
      seen      = seen || ((CW'(j) < cnt_r) && (act_r[j] == cur_r));
      act_rm[j] = seen ? act_r[(j + 1) % SLOTS] : act_r[j];
    end
  end

  always_comb begin
    tsum = (CW + 1)'(free_head_r) + (CW + 1)'(free_cnt_r);
    if (tsum >= (CW + 1)'(SLOTS)) begin
      tail = IW'(tsum - (CW + 1)'(SLOTS));
    end else begin
      tail = IW'(tsum);
    end
  end

  assign do_rel = ((state_r == S_DEV) && (op_r == OP_ACK) && key_match) ||
                  ((state_r == S_TEV) && (rec.countdown == 16'd0) &&
                   (rec.retries == 8'd0)) ||
                  (state_r == S_AEV);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      idx_r       <= '0;
      free_head_r <= '0;
      free_cnt_r  <= CW'(SLOTS);
      busy_r      <= '0;
      armed_r     <= '0;
      written_r   <= '0;
      res_v_r     <= 1'b0;
      pend_v_r    <= 1'b0;
      we_r        <= 1'b0;
      for (int j = 0; j < SLOTS; j++) begin
        free_r[j] <= IW'(j);
      end
    end else begin
      res_v_r <= 1'b0;
      we_r    <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            op_r  <= op_t'(in_op);
            ep_r  <= in_endpoint;
            key_r <= in_trans_key;
            cl_r  <= in_client_id;
            sv_r  <= in_server_id;
            ser_r <= in_local_serial;
            cur_r <= in_slot;
            idx_r <= '0;
            unique case (op_t'(in_op))
              OP_CALL, OP_RECALL: state_r <= S_SRD;
              OP_TICK: begin
                pend_v_r <= 1'b0;
                state_r  <= S_TRD;
              end
              OP_ABORT: begin
                if (cnt_r == '0) begin
                  res_r   <= '{default: '0, last: 1'b1};
                  res_v_r <= 1'b1;
                end else begin
                  state_r <= S_ARD;
                end
              end
              default: begin
                if (in_range && busy_r[in_slot]) begin
                  state_r <= S_DRD;
                end else begin
                  res_r <= echo_res((op_t'(in_op) == OP_SENDRET) ? ACT_CANCEL : ACT_NONE,
                                    EV_NOSLOT, in_endpoint, in_trans_key,
                                    in_client_id, in_server_id);
                  res_v_r <= 1'b1;
                end
              end
            endcase
          end
        end
        S_SRD: begin
          if (idx_r == cnt_r) begin
            if (free_cnt_r == '0) begin
              res_r   <= echo_res(ACT_NONE, EV_NOFREE, ep_r, key_r, cl_r, sv_r);
              res_v_r <= 1'b1;
              state_r <= S_IDLE;
            end else begin
              state_r <= S_ST1;
            end
          end else begin
            cur_r   <= act_r[idx_r[IW-1:0]];
            state_r <= S_SCMP;
          end
        end
        S_SCMP: begin
          if (key_match) begin
            res_v_r <= 1'b1;
            state_r <= S_IDLE;
            if (op_r == OP_CALL) begin
              res_r <= echo_res(ACT_NONE, EV_DUP, ep_r, key_r, cl_r, sv_r);
            end else if (rec.client != cl_r) begin
              res_r <= slot_res(ACT_NONE, EV_OK, rec, cur_r, 32'd0, 1'b1);
            end else if (rec.phase == PH_PENDING) begin
              res_r <= slot_res(ACT_NOINFO, EV_OK, rec, cur_r, 32'd0, 1'b1);
            end else if (rec.phase == PH_READY) begin
              res_r <= slot_res(ACT_RET, EV_OK, rec, cur_r, 32'd0, 1'b1);
            end else begin
              res_r <= slot_res(ACT_CANCEL, EV_OK, rec, cur_r, 32'd0, 1'b1);
            end
          end else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= S_SRD;
          end
        end
        S_ST1: begin
          cur_r       <= free_r[free_head_r];
          free_head_r <= (free_head_r == IW'(SLOTS - 1)) ? '0 : free_head_r + 1'b1;
          free_cnt_r  <= free_cnt_r - 1'b1;
          state_r     <= S_ST2;
        end
        S_ST2: begin
          slot_rec_t nr;
          nr.endpoint  = ep_r;
          nr.trans_key = key_r;
          nr.client    = cl_r;
          nr.serial    = (written_r[cur_r] ? rec.serial : 32'd0) + 32'd1;
          nr.retries   = cfg.max_retries;
          if (cfg.handler_attached) begin
            nr.phase         = PH_PENDING;
            nr.countdown     = 16'd0;
            armed_r[cur_r]  <= 1'b0;
            res_r <= slot_res(ACT_DELIVER, EV_OK, nr, cur_r, nr.serial, 1'b1);
          end else begin
            nr.phase         = PH_CANCELLED;
            nr.countdown     = cfg.retry_interval;
            armed_r[cur_r]  <= 1'b1;
            res_r <= slot_res(ACT_CANCEL, EV_OK, nr, cur_r, 32'd0, 1'b1);
          end
          res_v_r                <= 1'b1;
          busy_r[cur_r]          <= 1'b1;
          written_r[cur_r]       <= 1'b1;
          act_r[cnt_r[IW-1:0]]   <= cur_r;
          cnt_r                  <= cnt_r + 1'b1;
          we_r                   <= 1'b1;
          waddr_r                <= cur_r;
          wdata_r                <= nr;
          state_r                <= S_IDLE;
        end
        S_DRD: state_r <= S_DEV;
        S_DEV: begin
          slot_rec_t nr;
          nr      = rec;
          res_v_r <= 1'b1;
          state_r <= S_IDLE;
          unique case (op_r)
            OP_ACK: begin
              if (key_match) begin
                res_r <= slot_res(ACT_NONE, (rec.phase == PH_PENDING) ? EV_CLCANCEL :
                                  ((rec.phase == PH_READY) ? EV_DONE : EV_CANCELLED),
                                  rec, cur_r, 32'd0, 1'b1);
              end else begin
                res_r <= echo_res(ACT_NONE, EV_NOSLOT, ep_r, key_r, cl_r, sv_r);
              end
            end
            OP_SENDRET: begin
              if (!key_match) begin
                res_r <= echo_res(ACT_CANCEL, EV_NOSLOT, ep_r, key_r, cl_r, sv_r);
              end else if (rec.phase == PH_READY) begin
                res_r <= slot_res(ACT_RET, EV_OK, rec, cur_r, 32'd0, 1'b1);
              end else if (rec.phase == PH_PENDING) begin
                res_r <= slot_res(ACT_NONE, EV_OK, rec, cur_r, 32'd0, 1'b1);
              end else begin
                res_r <= slot_res(ACT_CANCEL, EV_OK, rec, cur_r, 32'd0, 1'b1);
              end
            end
            default: begin
              if ((rec.serial == ser_r) && (rec.phase == PH_PENDING)) begin
                nr.phase       = (op_r == OP_LREPLY) ? PH_READY : PH_CANCELLED;
                nr.countdown   = cfg.retry_interval;
                armed_r[cur_r] <= 1'b1;
                we_r           <= 1'b1;
                waddr_r        <= cur_r;
                wdata_r        <= nr;
                res_r <= slot_res((op_r == OP_LREPLY) ? ACT_RET : ACT_CANCEL, EV_OK,
                                  rec, cur_r, 32'd0, 1'b1);
              end else begin
                res_r <= echo_res(ACT_NONE, EV_NOSLOT, ep_r, key_r, cl_r, sv_r);
              end
            end
          endcase
        end
        S_TRD: begin
          if (idx_r == cnt_r) begin
            if (pend_v_r) begin
              res_r <= pend_r;
            end else begin
              res_r <= '{default: '0, last: 1'b1};
            end
            res_v_r <= 1'b1;
            state_r <= S_IDLE;
          end else if (armed_r[act_r[idx_r[IW-1:0]]]) begin
            cur_r   <= act_r[idx_r[IW-1:0]];
            state_r <= S_TEV;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        S_TEV: begin
          slot_rec_t nr;
          res_t      pr;
          nr      = rec;
          pr      = pend_r;
          pr.last = 1'b0;
          state_r <= S_TRD;
          if (rec.countdown != 16'd0) begin
            nr.countdown = rec.countdown - 16'd1;
            we_r    <= 1'b1;
            waddr_r <= cur_r;
            wdata_r <= nr;
            idx_r   <= idx_r + 1'b1;
          end else begin
            if (pend_v_r) begin
              res_r   <= pr;
              res_v_r <= 1'b1;
            end
            pend_v_r <= 1'b1;
            if (rec.retries != 8'd0) begin
              nr.retries   = rec.retries - 8'd1;
              nr.countdown = cfg.retry_interval;
              we_r    <= 1'b1;
              waddr_r <= cur_r;
              wdata_r <= nr;
              idx_r   <= idx_r + 1'b1;
              pend_r  <= slot_res(ACT_RERET, EV_OK, rec, cur_r, 32'd0, 1'b1);
            end else begin
              pend_r  <= slot_res(ACT_NONE, EV_TIMEOUT, rec, cur_r, 32'd0, 1'b1);
            end
          end
        end
        S_ARD: begin
          cur_r   <= act_r[0];
          state_r <= S_AEV;
        end
        S_AEV: begin
          res_r   <= slot_res(ACT_NONE, EV_ABORTED, rec, cur_r, 32'd0, cnt_r == CW'(1));
          res_v_r <= 1'b1;
          state_r <= (cnt_r == CW'(1)) ? S_IDLE : S_ARD;
        end
        default: state_r <= S_IDLE;
      endcase
      if (do_rel) begin
        busy_r[cur_r] <= 1'b0;
        act_r         <= act_rm;
        cnt_r         <= cnt_r - 1'b1;
        free_r[tail]  <= cur_r;
        free_cnt_r    <= free_cnt_r + 1'b1;
      end
    end
  end

endmodule

// ----- design/tss_chk.sv -----
// ----------------------------------------------------------------------------
// tss_chk
// Port-level checks of the transaction slot server, bound to the top level.
// ----------------------------------------------------------------------------
module tss_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_valid,
  input logic [2:0] out_action,
  input logic [3:0] out_event_res,
  input logic       out_last
);
  import tss_pkg::*;

  a_accept_answered: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy || out_valid)
    else $error("accepted word left no trace");

  a_more_follow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |=> busy || out_valid)
    else $error("result without last while idle");

  a_deliver_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_action == ACT_DELIVER) |-> (out_event_res == EV_OK) && out_last)
    else $error("delivery result malformed");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !busy && !out_valid)
    else $error("activity right after reset");

endmodule

bind transaction_slot_server tss_chk u_tss_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .out_valid     (out_valid),
  .out_action    (out_action),
  .out_event_res (out_event_res),
  .out_last      (out_last)
);
